### hdl/rcf_pkg.sv
// ----------------------------------------------------------------------------
// rcf_pkg: shared types and constants of the chunk framer
// Holds the field codes, the register indexes and the job record that passes
// from the front end to the back end, along with the basic-header helpers.
// ----------------------------------------------------------------------------
package rcf_pkg;

   // input item kinds
   localparam logic FUNC_HEADER = 1'b0;
   localparam logic FUNC_BODY   = 1'b1;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYSTEM_CH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MEDIA_CH   = 2'd2;
   localparam int CSR_DATA_W = 24;

   // register reset values
   localparam logic [23:0] CHUNK_SIZE_RESET = 24'd0;
   localparam logic [16:0] SYSTEM_CH_RESET  = 17'd2;
   localparam logic [16:0] MEDIA_CH_RESET   = 17'd4;

   // chunk size used when the register holds zero
   localparam logic [23:0] DEFAULT_CHUNK = 24'd128;

   // timestamp escape value and basic-header thresholds
   localparam logic [31:0] TS_ESCAPE    = 32'h00FF_FFFF;
   localparam logic [16:0] CSID_ONE_MAX = 17'd64;
   localparam logic [16:0] CSID_TWO_MAX = 17'd320;
   localparam logic [16:0] CSID_BIAS    = 17'd64;

   // format bits in the top of the basic header
   localparam logic [7:0] FMT0_TOP = 8'h00;
   localparam logic [7:0] FMT3_TOP = 8'hC0;

   // message header length without basic header or extended timestamp
   localparam logic [4:0] MSG_HDR_LEN = 5'd11;
   localparam logic [4:0] EXT_TS_LEN  = 5'd4;

   // control message types
   localparam logic [7:0] TYPE_SET_CHUNK  = 8'd1;
   localparam logic [7:0] TYPE_USER_CTRL  = 8'd4;
   localparam logic [7:0] TYPE_WIN_ACK    = 8'd5;
   localparam logic [7:0] TYPE_PEER_BW    = 8'd6;
   localparam logic [7:0] TYPE_AMF0_CMD   = 8'd20;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // output job: a full message header, or a body byte with any chunk header
   typedef struct packed {
      logic        is_body;
      logic [16:0] csid;
      logic [1:0]  basic_len;
      logic        ext;
      logic [31:0] ts;
      logic [23:0] len;
      logic [7:0]  type_id;
      logic [31:0] msg_stream_id;
      logic [7:0]  data;
      logic        last;
      logic [4:0]  total;
   } job_type;

   // queue handshake toward the back end
   typedef struct packed {
      logic    valid;
      job_type job;
   } qout_type;

   function automatic logic is_control_type(logic [7:0] t);
      return (t == TYPE_SET_CHUNK) || (t == TYPE_USER_CTRL) || (t == TYPE_WIN_ACK) ||
             (t == TYPE_PEER_BW) || (t == TYPE_AMF0_CMD);
   endfunction

   function automatic logic [1:0] basic_hdr_len(logic [16:0] csid);
      if (csid < CSID_ONE_MAX) begin
         return 2'd1;
      end else if (csid < CSID_TWO_MAX) begin
         return 2'd2;
      end
      return 2'd3;
   endfunction

   // byte i of a basic header; the two- and three-byte forms carry id minus 64
   function automatic logic [7:0] basic_hdr_byte(logic [7:0] top, logic [16:0] csid,
                                                 logic [1:0] i);
      logic [16:0] biased;
      biased = csid - CSID_BIAS;
      if (csid < CSID_ONE_MAX) begin
         return top | {2'b00, csid[5:0]};
      end else if (csid < CSID_TWO_MAX) begin
         return (i == 2'd0) ? top : biased[7:0];
      end
      case (i)
         2'd0:    return top | 8'h01;
         2'd1:    return biased[7:0];
         default: return biased[15:8];
      endcase
   endfunction

endpackage

### hdl/rcf_req_if.sv
// ----------------------------------------------------------------------------
// rcf_req_if: request channel of the chunk framer
// Valid/ready channel carrying header and body requests.
// ----------------------------------------------------------------------------
interface rcf_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [7:0]  type_id;
   logic [31:0] msg_stream_id;
   logic [31:0] timestamp_ms;
   logic [23:0] message_length;
   logic [7:0]  data_byte;

   modport source (output valid, func, type_id, msg_stream_id, timestamp_ms, message_length,
                   data_byte, input ready);
   modport sink (input valid, func, type_id, msg_stream_id, timestamp_ms, message_length,
                 data_byte, output ready);
endinterface

### hdl/rcf_rsp_if.sv
// ----------------------------------------------------------------------------
// rcf_rsp_if: response channel of the chunk framer
// Valid/ready channel carrying one output stream byte per transfer.
// ----------------------------------------------------------------------------
interface rcf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       header_flag;
   logic       last_of_message;

   modport source (output valid, out_byte, header_flag, last_of_message, input ready);
   modport sink (input valid, out_byte, header_flag, last_of_message, output ready);
endinterface

### hdl/rtmp_chunk_framer_core.sv
// An accepted request's first byte passes the job queue, then the output register.
// One body byte per cycle unless rsp_chan stalls; a header request yields 12 to 18 bytes
// and a chunk boundary 1 to 7 header bytes, all paced by the one-byte output register.
// Requests are taken while the job queue (QUEUE_DEPTH entries) has room.
// Reset is synchronous: registers return to chunk size 0, channels 2 and 4, queue empty.
// ----------------------------------------------------------------------------
// rtmp_chunk_framer_core: chunk stream framer top level
// Front end tracks messages and queues jobs; back end serializes them to bytes.
// ----------------------------------------------------------------------------
module rtmp_chunk_framer_core import rcf_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   rcf_req_if.sink               req_chan,
   rcf_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic     q_push;
   logic     q_full;
   logic     q_pop;
   job_type  q_job;
   qout_type q_head;

   rcf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (q_job)
   );

   rcf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head)
   );

   rcf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .pop      (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

### hdl/rcf_queue.sv
// ----------------------------------------------------------------------------
// rcf_queue: job queue between front and back end
// Small register FIFO of job records; full blocks the front end.
// ----------------------------------------------------------------------------
module rcf_queue import rcf_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  job_type  push_job,
   output logic     full,
   input  logic     pop,
   output qout_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_FULL);
   assign head.valid = (count_ff != '0);
   assign head.job   = mem_ff[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### hdl/rcf_front.sv
// ----------------------------------------------------------------------------
// rcf_front: request intake and message tracking
// Holds the configuration registers and the per-message state, classifies
// each request and queues a job describing the bytes it produces.
// ----------------------------------------------------------------------------
module rcf_front import rcf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   rcf_req_if.sink               req_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  q_full,
   output logic                  q_push,
   output job_type               q_job
);

   logic [23:0] chunk_size_ff;
   logic [16:0] system_ch_ff;
   logic [16:0] media_ch_ff;

   logic [23:0] bytes_left_ff, bytes_left_in;
   logic [23:0] chunk_fill_ff, chunk_fill_in;
   logic [31:0] held_ts_ff, held_ts_in;
   logic        ext_ff, ext_in;
   logic        on_sys_ff, on_sys_in;

   logic        accept;
   logic        hdr_ctl;
   logic        hdr_ext;
   logic [16:0] hdr_csid;
   logic [16:0] body_csid;
   logic [23:0] chunk_limit;
   logic        new_chunk;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_size_ff <= CHUNK_SIZE_RESET;
         system_ch_ff  <= SYSTEM_CH_RESET;
         media_ch_ff   <= MEDIA_CH_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CHUNK_SIZE: chunk_size_ff <= csr_wdata[23:0];
            CSR_SYSTEM_CH:  system_ch_ff  <= csr_wdata[16:0];
            CSR_MEDIA_CH:   media_ch_ff   <= csr_wdata[16:0];
            default:        ;
         endcase
      end
   end

   // classify header fields
   assign hdr_ctl     = is_control_type(req_chan.type_id);
   assign hdr_ext     = (req_chan.timestamp_ms >= TS_ESCAPE);
   assign hdr_csid    = hdr_ctl ? system_ch_ff : media_ch_ff;
   assign body_csid   = on_sys_ff ? system_ch_ff : media_ch_ff;
   assign chunk_limit = (chunk_size_ff == '0) ? DEFAULT_CHUNK : chunk_size_ff;
   assign new_chunk   = (chunk_fill_ff >= chunk_limit);

   // build the job and the next message state
   always_comb begin
      bytes_left_in = bytes_left_ff;
      chunk_fill_in = chunk_fill_ff;
      held_ts_in    = held_ts_ff;
      ext_in        = ext_ff;
      on_sys_in     = on_sys_ff;
      q_push        = 1'b0;

      q_job.is_body       = 1'b0;
      q_job.csid          = hdr_csid;
      q_job.basic_len     = basic_hdr_len(hdr_csid);
      q_job.ext           = hdr_ext;
      q_job.ts            = req_chan.timestamp_ms;
      q_job.len           = req_chan.message_length;
      q_job.type_id       = req_chan.type_id;
      q_job.msg_stream_id = req_chan.msg_stream_id;
      q_job.data          = req_chan.data_byte;
      q_job.last          = (req_chan.message_length == '0);
      q_job.total         = {3'b000, q_job.basic_len} + MSG_HDR_LEN +
                            (hdr_ext ? EXT_TS_LEN : 5'd0);

      if (req_chan.func == FUNC_BODY) begin
         q_job.is_body   = 1'b1;
         q_job.csid      = body_csid;
         q_job.basic_len = basic_hdr_len(body_csid);
         q_job.ext       = ext_ff;
         q_job.ts        = held_ts_ff;
         q_job.last      = (bytes_left_ff == 24'd1);
         q_job.total     = new_chunk ?
                           ({3'b000, q_job.basic_len} + (ext_ff ? EXT_TS_LEN : 5'd0) + 5'd1) :
                           5'd1;
      end

      if (accept) begin
         if (req_chan.func == FUNC_HEADER) begin
            q_push        = 1'b1;
            bytes_left_in = req_chan.message_length;
            chunk_fill_in = '0;
            held_ts_in    = req_chan.timestamp_ms;
            ext_in        = hdr_ext;
            on_sys_in     = hdr_ctl;
         end else if (bytes_left_ff != '0) begin
            // queue the byte; body requests with no message open are dropped
            q_push        = 1'b1;
            bytes_left_in = bytes_left_ff - 1'b1;
            chunk_fill_in = new_chunk ? 24'd1 : chunk_fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
         chunk_fill_ff <= '0;
         held_ts_ff    <= '0;
         ext_ff        <= 1'b0;
         on_sys_ff     <= 1'b0;
      end else begin
         bytes_left_ff <= bytes_left_in;
         chunk_fill_ff <= chunk_fill_in;
         held_ts_ff    <= held_ts_in;
         ext_ff        <= ext_in;
         on_sys_ff     <= on_sys_in;
      end
   end

endmodule

### hdl/rcf_back.sv
// ----------------------------------------------------------------------------
// rcf_back: byte serializer
// Walks the head job byte by byte into an output register and pops the job
// once its final byte is loaded.
// ----------------------------------------------------------------------------
module rcf_back import rcf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  qout_type head,
   output logic     pop,
   rcf_rsp_if.source rsp_chan
);

   logic [4:0] idx_ff, idx_in;
   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       hdr_ff;
   logic       last_ff;

   job_type    job;
   logic       load;
   logic       final_byte;
   logic [4:0] rel;
   logic [4:0] ext_pos;
   logic [7:0] top;
   logic [23:0] ts_field;
   logic [7:0] cur_byte;
   logic       cur_hdr;

   assign job        = head.job;
   assign load       = head.valid && (!valid_ff || rsp_chan.ready);
   assign final_byte = (idx_ff == job.total - 5'd1);
   assign pop        = load && final_byte;
   assign rel        = idx_ff - {3'b000, job.basic_len};
   assign ext_pos    = rel - MSG_HDR_LEN;
   assign top        = job.is_body ? FMT3_TOP : FMT0_TOP;
   assign ts_field   = job.ext ? TS_ESCAPE[23:0] : job.ts[23:0];

   // select the byte at the current position
   always_comb begin
      cur_hdr  = 1'b1;
      cur_byte = '0;
      if (job.is_body && final_byte) begin
         cur_hdr  = 1'b0;
         cur_byte = job.data;
      end else if (idx_ff < {3'b000, job.basic_len}) begin
         cur_byte = basic_hdr_byte(top, job.csid, idx_ff[1:0]);
      end else if (job.is_body) begin
         case (rel[1:0])
            2'd0:    cur_byte = job.ts[31:24];
            2'd1:    cur_byte = job.ts[23:16];
            2'd2:    cur_byte = job.ts[15:8];
            default: cur_byte = job.ts[7:0];
         endcase
      end else begin
         case (rel)
            5'd0:    cur_byte = ts_field[23:16];
            5'd1:    cur_byte = ts_field[15:8];
            5'd2:    cur_byte = ts_field[7:0];
            5'd3:    cur_byte = job.len[23:16];
            5'd4:    cur_byte = job.len[15:8];
            5'd5:    cur_byte = job.len[7:0];
            5'd6:    cur_byte = job.type_id;
            5'd7:    cur_byte = job.msg_stream_id[31:24];
            5'd8:    cur_byte = job.msg_stream_id[23:16];
            5'd9:    cur_byte = job.msg_stream_id[15:8];
            5'd10:   cur_byte = job.msg_stream_id[7:0];
            default: begin
               case (ext_pos[1:0])
                  2'd0:    cur_byte = job.ts[31:24];
                  2'd1:    cur_byte = job.ts[23:16];
                  2'd2:    cur_byte = job.ts[15:8];
                  default: cur_byte = job.ts[7:0];
               endcase
            end
         endcase
      end
   end

   // advance position within the job
   always_comb begin
      idx_in = idx_ff;
      if (load) begin
         idx_in = final_byte ? 5'd0 : idx_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // hold the output byte until taken
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= cur_byte;
         hdr_ff  <= cur_hdr;
         last_ff <= job.last && final_byte;
      end
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.out_byte        = byte_ff;
   assign rsp_chan.header_flag     = hdr_ff;
   assign rsp_chan.last_of_message = last_ff;

endmodule
